// ----- design/gcpe_pkg.sv -----
// ----------------------------------------------------------------------------
// Growing cross-product enumerator package
// Shared constants, codes and types of the enumerator block.
// ----------------------------------------------------------------------------
package gcpe_pkg;

   localparam int SLOW_MAX   = 64;
   localparam int FAST_MAX   = 1024;

   localparam int SLOW_IDX_W = $clog2(SLOW_MAX);
   localparam int SLOW_CNT_W = $clog2(SLOW_MAX + 1);
   localparam int FAST_W     = $clog2(FAST_MAX + 2);
   localparam int REM_W      = $clog2(SLOW_MAX * FAST_MAX + 1);

   localparam logic [SLOW_CNT_W-1:0] SLOW_LIMIT = SLOW_CNT_W'(SLOW_MAX);
   localparam logic [FAST_W-1:0]     FAST_LIMIT = FAST_W'(FAST_MAX);
   localparam logic [FAST_W-1:0]     FAST_SAT   = FAST_W'(FAST_MAX + 1);

   localparam logic CMD_PEEK    = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_CUR,
      ST_BUMP,
      ST_SCAN,
      ST_FINAL_RD,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic                  rd_en;
      logic [SLOW_IDX_W-1:0] rd_addr;
      logic                  wr_en;
      logic [SLOW_IDX_W-1:0] wr_addr;
      logic [FAST_W-1:0]     wr_data;
   } tbl_req_type;

endpackage

// ----- design/gcpe_req_if.sv -----
// ----------------------------------------------------------------------------
// Enumerator request channel
// Valid/ready channel that carries one command with the two list lengths.
// ----------------------------------------------------------------------------
interface gcpe_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [6:0]  slow_count;
   logic [10:0] fast_count;

   modport source (output valid, cmd, slow_count, fast_count, input ready);
   modport sink   (input valid, cmd, slow_count, fast_count, output ready);
endinterface

// ----- design/gcpe_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Enumerator response channel
// Valid/ready channel that carries the current pair and the remaining count.
// ----------------------------------------------------------------------------
interface gcpe_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  pair_slow;
   logic [10:0] pair_fast;
   logic        pair_valid;
   logic [16:0] remaining_count;

   modport source (output valid, pair_slow, pair_fast, pair_valid, remaining_count,
                   input ready);
   modport sink   (input valid, pair_slow, pair_fast, pair_valid, remaining_count,
                   output ready);
endinterface

// ----- design/gcpe_table.sv -----
// ----------------------------------------------------------------------------
// Fast position table
// Single-port-read, single-port-write memory of per-slow-entry counters with
// one valid bit per entry so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
module gcpe_table (
   input  logic                        clock,
   input  logic                        reset,
   input  gcpe_pkg::tbl_req_type       tbl_req,
   output logic [gcpe_pkg::FAST_W-1:0] rd_data
);

   logic [gcpe_pkg::FAST_W-1:0] mem [gcpe_pkg::SLOW_MAX];
   logic [gcpe_pkg::SLOW_MAX-1:0] vld_ff;
   logic [gcpe_pkg::FAST_W-1:0]   rd_q_ff;
   logic                          rd_vld_ff;

   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         mem[tbl_req.wr_addr] <= tbl_req.wr_data;
      end
      if (tbl_req.rd_en) begin
         rd_q_ff <= mem[tbl_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (tbl_req.wr_en) begin
            vld_ff[tbl_req.wr_addr] <= 1'b1;
         end
         if (tbl_req.rd_en) begin
            rd_vld_ff <= vld_ff[tbl_req.rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule

// ----- design/growing_cross_product_enumerator.sv -----
// ----------------------------------------------------------------------------
// Growing cross-product enumerator
// Walks (slow, fast) index pairs over two growing lists using a counter table.
// ----------------------------------------------------------------------------
// An advance with a nonempty slow list first reads and bumps the counter of the
// current entry; every command then scans the n entries of the clamped slow list
// and reads the chosen entry once more before it responds. One transaction at a
// time is taken; the scan reads one table entry per cycle and then drains the last read.
// Reset clears the position, the control state and all table valid bits at once.
// ----------------------------------------------------------------------------
module growing_cross_product_enumerator (
   input  logic        clock,
   input  logic        reset,
   gcpe_req_if.sink    req_bus,
   gcpe_rsp_if.source  rsp_bus
);

   gcpe_pkg::state_type state_ff, state_in;
   gcpe_pkg::tbl_req_type tbl_req;
   logic [gcpe_pkg::FAST_W-1:0] rd_data;

   logic                              cmd_ff;
   logic [gcpe_pkg::SLOW_CNT_W-1:0]   n_ff;
   logic [gcpe_pkg::FAST_W-1:0]       f_ff;
   logic [gcpe_pkg::SLOW_IDX_W-1:0]   cur_ff, cur_in;
   logic [gcpe_pkg::SLOW_CNT_W-1:0]   idx_ff;
   logic                              pend_ff;
   logic [gcpe_pkg::SLOW_IDX_W-1:0]   pidx_ff;
   logic                              found_ff;
   logic [gcpe_pkg::SLOW_IDX_W-1:0]   first_ff;
   logic [gcpe_pkg::REM_W-1:0]        sum_ff;

   logic                              rsp_valid_ff;
   logic [gcpe_pkg::SLOW_IDX_W-1:0]   rsp_slow_ff;
   logic [gcpe_pkg::FAST_W-1:0]       rsp_fast_ff;
   logic                              rsp_pvalid_ff;
   logic [gcpe_pkg::REM_W-1:0]        rsp_rem_ff;

   logic                              accept;
   logic                              advance;
   logic                              scan_issue;
   logic                              rsp_free;
   logic                              load_rsp;
   logic                              hit;
   logic                              final_valid;
   logic [gcpe_pkg::SLOW_CNT_W-1:0]   n_last;

   gcpe_table u_table (
      .clock   (clock),
      .reset   (reset),
      .tbl_req (tbl_req),
      .rd_data (rd_data)
   );

   assign advance    = (cmd_ff == gcpe_pkg::CMD_ADVANCE) && (n_ff != '0);
   assign scan_issue = (state_ff == gcpe_pkg::ST_SCAN) && (idx_ff < n_ff);
   assign rsp_free   = !rsp_valid_ff || rsp_bus.ready;
   assign accept     = req_bus.valid && req_bus.ready;
   assign hit        = rd_data < f_ff;
   assign n_last     = n_ff - gcpe_pkg::SLOW_CNT_W'(1);
   assign final_valid = ({1'b0, cur_ff} < n_ff) && hit;

   always_comb begin
      if (advance) begin
         cur_in = found_ff ? first_ff : n_last[gcpe_pkg::SLOW_IDX_W-1:0];
      end else begin
         cur_in = cur_ff;
      end
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gcpe_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               if ((req_bus.cmd == gcpe_pkg::CMD_ADVANCE) && (req_bus.slow_count != '0)) begin
                  state_in = gcpe_pkg::ST_RD_CUR;
               end else begin
                  state_in = gcpe_pkg::ST_SCAN;
               end
            end
         end
         gcpe_pkg::ST_RD_CUR:   state_in = gcpe_pkg::ST_BUMP;
         gcpe_pkg::ST_BUMP:     state_in = gcpe_pkg::ST_SCAN;
         gcpe_pkg::ST_SCAN: begin
            if (!scan_issue && !pend_ff) begin
               state_in = gcpe_pkg::ST_FINAL_RD;
            end
         end
         gcpe_pkg::ST_FINAL_RD: state_in = gcpe_pkg::ST_FINAL;
         gcpe_pkg::ST_FINAL: begin
            if (rsp_free) begin
               state_in = gcpe_pkg::ST_IDLE;
            end
         end
         default:               state_in = gcpe_pkg::ST_IDLE;
      endcase
   end

   // Output logic.
   always_comb begin
      req_bus.ready   = 1'b0;
      load_rsp        = 1'b0;
      tbl_req.rd_en   = 1'b0;
      tbl_req.rd_addr = cur_ff;
      tbl_req.wr_en   = 1'b0;
      tbl_req.wr_addr = cur_ff;
      tbl_req.wr_data = (rd_data < gcpe_pkg::FAST_SAT) ?
                        rd_data + gcpe_pkg::FAST_W'(1) : rd_data;
      case (state_ff)
         gcpe_pkg::ST_IDLE:     req_bus.ready = 1'b1;
         gcpe_pkg::ST_RD_CUR:   tbl_req.rd_en = 1'b1;
         gcpe_pkg::ST_BUMP:     tbl_req.wr_en = 1'b1;
         gcpe_pkg::ST_SCAN: begin
            tbl_req.rd_en   = scan_issue;
            tbl_req.rd_addr = idx_ff[gcpe_pkg::SLOW_IDX_W-1:0];
         end
         gcpe_pkg::ST_FINAL_RD: begin
            tbl_req.rd_en   = 1'b1;
            tbl_req.rd_addr = cur_in;
         end
         gcpe_pkg::ST_FINAL:    load_rsp = rsp_free;
         default:               req_bus.ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gcpe_pkg::ST_IDLE;
         cur_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= scan_issue;
         if (state_ff == gcpe_pkg::ST_FINAL_RD) begin
            cur_ff <= cur_in;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_bus.cmd;
         n_ff     <= (req_bus.slow_count > gcpe_pkg::SLOW_LIMIT) ?
                     gcpe_pkg::SLOW_LIMIT : req_bus.slow_count;
         f_ff     <= (req_bus.fast_count > gcpe_pkg::FAST_LIMIT) ?
                     gcpe_pkg::FAST_LIMIT : req_bus.fast_count;
         idx_ff   <= '0;
         found_ff <= 1'b0;
         first_ff <= '0;
         sum_ff   <= '0;
      end else begin
         if (scan_issue) begin
            idx_ff <= idx_ff + gcpe_pkg::SLOW_CNT_W'(1);
         end
         if (pend_ff && hit) begin
            sum_ff <= sum_ff + gcpe_pkg::REM_W'(f_ff - rd_data);
            if (!found_ff) begin
               found_ff <= 1'b1;
               first_ff <= pidx_ff;
            end
         end
      end
      pidx_ff <= idx_ff[gcpe_pkg::SLOW_IDX_W-1:0];
      if (load_rsp) begin
         rsp_slow_ff   <= cur_ff;
         rsp_fast_ff   <= rd_data;
         rsp_pvalid_ff <= final_valid;
         rsp_rem_ff    <= final_valid ? sum_ff : '0;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.pair_slow       = rsp_slow_ff;
   assign rsp_bus.pair_fast       = rsp_fast_ff;
   assign rsp_bus.pair_valid      = rsp_pvalid_ff;
   assign rsp_bus.remaining_count = rsp_rem_ff;

endmodule

// ----- design/gcpe_checker.sv -----
// ----------------------------------------------------------------------------
// Enumerator port checker
// Concurrent checks on the response port of the enumerator, bound to the top.
// ----------------------------------------------------------------------------
module gcpe_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [10:0] pair_fast,
   input logic        pair_valid,
   input logic [16:0] remaining_count
);

   localparam logic [16:0] REM_LIMIT = 17'(gcpe_pkg::SLOW_MAX * gcpe_pkg::FAST_MAX);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(remaining_count))
      else $error("Response changed while stalled.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response valid right after reset.");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !pair_valid |-> remaining_count == '0)
      else $error("Invalid pair with nonzero remaining count.");

   a_valid_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pair_valid |-> remaining_count != '0 &&
                                  remaining_count <= REM_LIMIT &&
                                  pair_fast < 11'(gcpe_pkg::FAST_MAX))
      else $error("Valid pair inconsistent with remaining count or fast index.");

endmodule

bind growing_cross_product_enumerator gcpe_checker u_gcpe_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .pair_fast       (rsp_bus.pair_fast),
   .pair_valid      (rsp_bus.pair_valid),
   .remaining_count (rsp_bus.remaining_count)
);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Growing cross-product enumerator testbench
// Drives peek and advance transactions over growing, shrinking and oversized
// list lengths and checks every response against a cycle-free model of the
// counter table or against known values for some directed rows. Both channels
// idle at random, and the response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [gcpe_pkg::SLOW_IDX_W-1:0] pair_slow;
      logic [gcpe_pkg::FAST_W-1:0]     pair_fast;
      logic                            pair_valid;
      logic [gcpe_pkg::REM_W-1:0]      remaining_count;
   } pair_report_type;

   typedef struct packed {
      logic            cmd;
      logic [6:0]      slow_count;
      logic [10:0]     fast_count;
      logic            has_known;
      pair_report_type known;
   } directed_row_type;

   localparam int N_DIRECTED = 20;
   localparam directed_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      '{gcpe_pkg::CMD_PEEK,    7'd0,   11'd0,    1'b1, '{6'd0, 11'd0, 1'b0, 17'd0}},
      '{gcpe_pkg::CMD_ADVANCE, 7'd0,   11'd5,    1'b1, '{6'd0, 11'd0, 1'b0, 17'd0}},
      '{gcpe_pkg::CMD_PEEK,    7'd64,  11'd1024, 1'b1, '{6'd0, 11'd0, 1'b1, 17'd65536}},
      '{gcpe_pkg::CMD_PEEK,    7'd127, 11'd2047, 1'b1, '{6'd0, 11'd0, 1'b1, 17'd65536}},
      '{gcpe_pkg::CMD_PEEK,    7'd1,   11'd0,    1'b1, '{6'd0, 11'd0, 1'b0, 17'd0}},
      '{gcpe_pkg::CMD_ADVANCE, 7'd1,   11'd2,    1'b1, '{6'd0, 11'd1, 1'b1, 17'd1}},
      '{gcpe_pkg::CMD_ADVANCE, 7'd1,   11'd2,    1'b0, '0},
      '{gcpe_pkg::CMD_ADVANCE, 7'd1,   11'd2,    1'b0, '0},
      '{gcpe_pkg::CMD_ADVANCE, 7'd3,   11'd2,    1'b0, '0},
      '{gcpe_pkg::CMD_ADVANCE, 7'd3,   11'd2,    1'b0, '0},
      '{gcpe_pkg::CMD_PEEK,    7'd1,   11'd2,    1'b0, '0},
      '{gcpe_pkg::CMD_ADVANCE, 7'd1,   11'd2,    1'b0, '0},
      '{gcpe_pkg::CMD_PEEK,    7'd3,   11'd2,    1'b0, '0},
      '{gcpe_pkg::CMD_ADVANCE, 7'd3,   11'd5,    1'b0, '0},
      '{gcpe_pkg::CMD_ADVANCE, 7'd127, 11'd2047, 1'b0, '0},
      '{gcpe_pkg::CMD_ADVANCE, 7'd64,  11'd1024, 1'b0, '0},
      '{gcpe_pkg::CMD_PEEK,    7'd64,  11'd0,    1'b0, '0},
      '{gcpe_pkg::CMD_ADVANCE, 7'd0,   11'd2047, 1'b0, '0},
      '{gcpe_pkg::CMD_PEEK,    7'd2,   11'd1,    1'b0, '0},
      '{gcpe_pkg::CMD_ADVANCE, 7'd64,  11'd1,    1'b0, '0}
   };

   logic clock;
   logic reset;

   gcpe_req_if req_ch ();
   gcpe_rsp_if rsp_ch ();

   growing_cross_product_enumerator DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   logic [gcpe_pkg::FAST_W-1:0]     fast_pos_tbl [gcpe_pkg::SLOW_MAX];
   logic [gcpe_pkg::SLOW_IDX_W-1:0] slow_cursor;
   pair_report_type                 reports_due [$];
   int                              fail_count   = 0;
   int                              results_seen = 0;
   int                              burst_left   = 0;
   bit                              req_held     = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic pair_report_type enumerate_step(input logic cmd,
                                                      input logic [6:0] slow_len,
                                                      input logic [10:0] fast_len);
      int              n;
      int              f;
      int              i;
      int              hit;
      longint          sum;
      pair_report_type r;
      n = (slow_len > gcpe_pkg::SLOW_MAX) ? gcpe_pkg::SLOW_MAX : int'(slow_len);
      f = (fast_len > gcpe_pkg::FAST_MAX) ? gcpe_pkg::FAST_MAX : int'(fast_len);
      if (cmd == gcpe_pkg::CMD_ADVANCE && n > 0) begin
         if (fast_pos_tbl[slow_cursor] < gcpe_pkg::FAST_SAT) begin
            fast_pos_tbl[slow_cursor] = fast_pos_tbl[slow_cursor] + 1'b1;
         end
         hit = n - 1;
         for (i = n - 1; i >= 0; i--) begin
            if (int'(fast_pos_tbl[i]) < f) begin
               hit = i;
            end
         end
         slow_cursor = gcpe_pkg::SLOW_IDX_W'(hit);
      end
      r.pair_slow  = slow_cursor;
      r.pair_fast  = fast_pos_tbl[slow_cursor];
      r.pair_valid = (int'(slow_cursor) < n) && (int'(fast_pos_tbl[slow_cursor]) < f);
      sum = 0;
      if (r.pair_valid) begin
         for (i = 0; i < n; i++) begin
            if (int'(fast_pos_tbl[i]) < f) begin
               sum += f - int'(fast_pos_tbl[i]);
            end
         end
      end
      r.remaining_count = gcpe_pkg::REM_W'(sum);
      return r;
   endfunction

   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_ch.valid <= 1'b0;
         req_held = 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(20, 60)) :
                                                    int'($urandom_range(0, 10));
      end
   endtask

   task automatic offer(input logic cmd, input logic [6:0] slow_len, input logic [10:0] fast_len,
                        input logic has_known, input pair_report_type known);
      pair_report_type predicted;
      pair_report_type expected;
      req_ch.valid      <= 1'b1;
      req_ch.cmd        <= cmd;
      req_ch.slow_count <= slow_len;
      req_ch.fast_count <= fast_len;
      req_held = 1;
      do @(posedge clock); while (!req_ch.ready);
      predicted = enumerate_step(cmd, slow_len, fast_len);
      expected  = has_known ? known : predicted;
      reports_due = {reports_due, expected};
      pace_sender();
   endtask

   initial begin
      int          k;
      int          sl;
      int          fl;
      int          sat_extra;
      logic        cmd;
      logic [6:0]  s;
      logic [10:0] f;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.cmd        <= gcpe_pkg::CMD_PEEK;
      req_ch.slow_count <= '0;
      req_ch.fast_count <= '0;
      for (k = 0; k < gcpe_pkg::SLOW_MAX; k++) begin
         fast_pos_tbl[k] = '0;
      end
      slow_cursor = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < N_DIRECTED; k++) begin
         offer(DIRECTED_ROWS[k].cmd, DIRECTED_ROWS[k].slow_count, DIRECTED_ROWS[k].fast_count,
               DIRECTED_ROWS[k].has_known, DIRECTED_ROWS[k].known);
      end

      // Lists grow slowly so that the enumeration keeps up and often runs dry.
      sl = 1;
      fl = 1;
      for (k = 0; k < 850; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            cmd = 1'($urandom_range(0, 1));
            s   = 7'($urandom_range(0, 127));
            f   = 11'($urandom_range(0, 2047));
         end else begin
            if ($urandom_range(0, 39) == 0 && sl < gcpe_pkg::SLOW_MAX) begin
               sl++;
            end
            if ($urandom_range(0, 24) == 0) begin
               fl = fl + int'($urandom_range(1, 3));
               if (fl > gcpe_pkg::FAST_MAX) begin
                  fl = gcpe_pkg::FAST_MAX;
               end
            end
            cmd = ($urandom_range(0, 3) != 0) ? gcpe_pkg::CMD_ADVANCE : gcpe_pkg::CMD_PEEK;
            s   = 7'(sl);
            f   = 11'(fl);
         end
         offer(cmd, s, f, 1'b0, '0);
      end

      // A single slow entry is advanced until its counter saturates and for twenty transactions more.
      sat_extra = 20;
      while (sat_extra > 0) begin
         if (fast_pos_tbl[0] == gcpe_pkg::FAST_SAT) begin
            sat_extra--;
         end
         cmd = ($urandom_range(0, 15) != 0) ? gcpe_pkg::CMD_ADVANCE : gcpe_pkg::CMD_PEEK;
         s   = ($urandom_range(0, 15) != 0) ? 7'd1 : 7'd0;
         f   = 11'($urandom_range(0, 2047));
         offer(cmd, s, f, 1'b0, '0);
      end

      if (req_held) begin
         req_ch.valid <= 1'b0;
      end
      while (reports_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("growing_cross_product_enumerator verification clean");
      end else begin
         $display("growing_cross_product_enumerator verification failed");
      end
      $finish;
   end

   initial begin
      int cyc;
      int hold_left;
      int mode;
      bit long_hold_done;
      rsp_ch.ready <= 1'b0;
      cyc            = 0;
      hold_left      = 0;
      mode           = 0;
      long_hold_done = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!long_hold_done && results_seen >= 400) begin
            hold_left      = 600;
            long_hold_done = 1;
         end
         if (cyc % 50 == 0) begin
            mode = int'($urandom_range(0, 3));
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (mode)
               0: begin
                  rsp_ch.ready <= 1'b1;
               end
               1: begin
                  rsp_ch.ready <= 1'($urandom_range(0, 1));
               end
               2: begin
                  rsp_ch.ready <= ($urandom_range(0, 4) == 0);
               end
               default: begin
                  rsp_ch.ready <= ((cyc / 4) % 2 == 1);
               end
            endcase
         end
         cyc++;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      pair_report_type due;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (reports_due.size() == 0) begin
            $error("Response arrived with no transaction pending.");
            fail_count++;
         end else begin
            due = reports_due.pop_front();
            if (rsp_ch.pair_slow !== due.pair_slow) begin
               $error("pair_slow: expected %0d, got %0d", due.pair_slow, rsp_ch.pair_slow);
               fail_count++;
            end
            if (rsp_ch.pair_fast !== due.pair_fast) begin
               $error("pair_fast: expected %0d, got %0d", due.pair_fast, rsp_ch.pair_fast);
               fail_count++;
            end
            if (rsp_ch.pair_valid !== due.pair_valid) begin
               $error("pair_valid: expected %0d, got %0d", due.pair_valid, rsp_ch.pair_valid);
               fail_count++;
            end
            if (rsp_ch.remaining_count !== due.remaining_count) begin
               $error("remaining_count: expected %0d, got %0d", due.remaining_count,
                      rsp_ch.remaining_count);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("growing_cross_product_enumerator verification failed");
      $finish;
   end

endmodule
